// ===== rtl/csmh_pkg.sv =====
// package: widths, types and helpers for the cuboid stacking block
package csmh_pkg;
  localparam int MaxCuboids = 128;
  localparam int DimBits = 16;
  localparam int IdxBits = $clog2(MaxCuboids);
  localparam int CntBits = $clog2(MaxCuboids + 1);
  localparam int HgtBits = 23;
  localparam logic [HgtBits-1:0] HeightMax = {HgtBits{1'b1}};

  typedef logic [DimBits-1:0] dim_t;
  typedef logic [HgtBits-1:0] hgt_t;
  typedef logic [IdxBits-1:0] idx_t;
  typedef logic [CntBits-1:0] cnt_t;

  typedef struct packed {
    dim_t d2;
    dim_t d1;
    dim_t d0;
  } box_t;

  function automatic logic box_gt(box_t x, box_t y);
    if (x.d0 != y.d0) return x.d0 > y.d0;
    if (x.d1 != y.d1) return x.d1 > y.d1;
    return x.d2 > y.d2;
  endfunction

  function automatic logic fits_on(box_t top, box_t base);
    return top.d0 <= base.d0 && top.d1 <= base.d1 && top.d2 <= base.d2;
  endfunction

  function automatic box_t sort3(dim_t a, dim_t b, dim_t c);
    dim_t x, y, z, t;
    x = a; y = b; z = c;
    if (x > y) begin t = x; x = y; y = t; end
    if (y > z) begin t = y; y = z; z = t; end
    if (x > y) begin t = x; x = y; y = t; end
    return '{d2: z, d1: y, d0: x};
  endfunction
endpackage

// ===== rtl/csmh_if.sv =====
// valid/ready channel interfaces for input and result beats
interface csmh_in_if;
  import csmh_pkg::*;
  logic valid;
  logic ready;
  dim_t dim_a;
  dim_t dim_b;
  dim_t dim_c;
  logic last;
  modport source (output valid, dim_a, dim_b, dim_c, last, input ready);
  modport sink (input valid, dim_a, dim_b, dim_c, last, output ready);
endinterface

interface csmh_out_if;
  import csmh_pkg::*;
  logic valid;
  logic ready;
  hgt_t max_height;
  logic overflow;
  modport source (output valid, max_height, overflow, input ready);
  modport sink (input valid, max_height, overflow, output ready);
endinterface

// ===== rtl/csmh_ram.sv =====
// generic single-port-write, one-read synchronous ram
module csmh_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/csmh_ctrl.sv =====
// sequencer: load, insertion sort and chain dp over the two rams
module csmh_ctrl
  import csmh_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  csmh_in_if.sink    in_ch,
  csmh_out_if.source out_ch,
  output logic bx_we,
  output idx_t bx_waddr,
  output box_t bx_wdata,
  output idx_t bx_raddr,
  input  box_t bx_rdata,
  output logic hb_we,
  output idx_t hb_waddr,
  output hgt_t hb_wdata,
  output idx_t hb_raddr,
  input  hgt_t hb_rdata
);
  typedef enum logic [3:0] {
    S_LOAD, S_SI_RD, S_SI_KEY, S_SJ_RD, S_SJ_CMP,
    S_DI_RD, S_DI_BASE, S_DJ_CMP, S_DJ_HGT
  } state_t;

  state_t state_r;
  cnt_t cnt_r, i_r, j_r;
  logic drop_r;
  box_t key_r, cand_r;
  hgt_t below_r, best_r;
  logic out_valid_r;
  hgt_t out_h_r;
  logic out_o_r;
  logic [HgtBits:0] sum;
  box_t srt;

  assign srt = sort3(in_ch.dim_a, in_ch.dim_b, in_ch.dim_c);
  assign in_ch.ready = (state_r == S_LOAD) && !out_valid_r;
  assign out_ch.valid = out_valid_r;
  assign out_ch.max_height = out_h_r;
  assign out_ch.overflow = out_o_r;
  assign sum = {1'b0, hgt_t'(key_r.d2)} + {1'b0, below_r};

  always_comb begin
    bx_we = 1'b0;
    bx_waddr = idx_t'(cnt_r);
    bx_wdata = srt;
    bx_raddr = idx_t'(i_r);
    hb_we = 1'b0;
    hb_waddr = idx_t'(i_r);
    hb_wdata = sum[HgtBits] ? HeightMax : sum[HgtBits-1:0];
    hb_raddr = idx_t'(j_r);
    case (state_r)
      S_LOAD: bx_we = in_ch.valid && in_ch.ready && cnt_r < cnt_t'(MaxCuboids);
      S_SI_RD, S_DI_RD: bx_raddr = idx_t'(i_r);
      S_SI_KEY, S_SJ_RD: bx_raddr = idx_t'(j_r - 1'b1);
      S_SJ_CMP: begin
        bx_raddr = idx_t'(j_r - 1'b1);
        bx_waddr = idx_t'(j_r);
        bx_we = 1'b1;
        bx_wdata = (j_r != '0 && box_gt(bx_rdata, key_r)) ? bx_rdata : key_r;
      end
      S_DI_BASE: bx_raddr = idx_t'(j_r);
      S_DJ_CMP: begin
        hb_raddr = idx_t'(j_r);
        if (j_r == i_r) hb_we = 1'b1;
      end
      S_DJ_HGT: bx_raddr = idx_t'(j_r + 1'b1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r <= '0;
      drop_r <= 1'b0;
      out_valid_r <= 1'b0;
      i_r <= '0;
      j_r <= '0;
    end else begin
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      case (state_r)
        S_LOAD: if (in_ch.valid && in_ch.ready) begin
          if (cnt_r < cnt_t'(MaxCuboids)) cnt_r <= cnt_r + 1'b1;
          else drop_r <= 1'b1;
          if (in_ch.last) begin
            out_o_r <= drop_r || cnt_r == cnt_t'(MaxCuboids);
            i_r <= cnt_t'(1);
            state_r <= S_SI_RD;
          end
        end
        S_SI_RD: begin
          if (i_r >= cnt_r) begin
            i_r <= '0;
            best_r <= '0;
            state_r <= S_DI_RD;
          end else state_r <= S_SI_KEY;
        end
        S_SI_KEY: begin
          key_r <= bx_rdata;
          j_r <= i_r;
          state_r <= S_SJ_RD;
        end
        S_SJ_RD: state_r <= S_SJ_CMP;
        S_SJ_CMP: begin
          if (j_r != '0 && box_gt(bx_rdata, key_r)) begin
            j_r <= j_r - 1'b1;
            state_r <= S_SJ_RD;
          end else begin
            i_r <= i_r + 1'b1;
            state_r <= S_SI_RD;
          end
        end
        S_DI_RD: begin
          if (i_r >= cnt_r) begin
            out_h_r <= best_r;
            out_valid_r <= 1'b1;
            cnt_r <= '0;
            drop_r <= 1'b0;
            state_r <= S_LOAD;
          end else begin
            j_r <= '0;
            below_r <= '0;
            state_r <= S_DI_BASE;
          end
        end
        S_DI_BASE: begin
          key_r <= bx_rdata;
          state_r <= S_DJ_CMP;
        end
        S_DJ_CMP: begin
          if (j_r == i_r) begin
            if (hb_wdata > best_r) best_r <= hb_wdata;
            i_r <= i_r + 1'b1;
            state_r <= S_DI_RD;
          end else begin
            cand_r <= bx_rdata;
            state_r <= S_DJ_HGT;
          end
        end
        S_DJ_HGT: begin
          if (fits_on(cand_r, key_r) && hb_rdata > below_r) below_r <= hb_rdata;
          j_r <= j_r + 1'b1;
          state_r <= S_DJ_CMP;
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end
endmodule

// ===== rtl/cuboid_stack_max_height.sv =====
// Cuboid stacking: cuboids load at one beat per cycle into a 128-entry box RAM,
// sorted by dimension on entry. The beat with last starts a solve: an insertion
// sort through the single RAM read port, then the chain pass over each
// pair (i, j<i). No beat is taken during the solve or while the result
// waits. Overflow reports cuboids dropped beyond capacity.
module cuboid_stack_max_height
  import csmh_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  csmh_in_if.sink    in_ch,
  csmh_out_if.source out_ch
);
  logic bx_we, hb_we;
  idx_t bx_waddr, bx_raddr, hb_waddr, hb_raddr;
  box_t bx_wdata, bx_rdata;
  hgt_t hb_wdata, hb_rdata;

  csmh_ctrl u_ctrl (.*);

  csmh_ram #(.Width($bits(box_t)), .Depth(MaxCuboids)) u_box (
    .clk, .we(bx_we), .waddr(bx_waddr), .wdata(bx_wdata), .raddr(bx_raddr),
    .rdata(bx_rdata));
  csmh_ram #(.Width(HgtBits), .Depth(MaxCuboids)) u_best (
    .clk, .we(hb_we), .waddr(hb_waddr), .wdata(hb_wdata), .raddr(hb_raddr),
    .rdata(hb_rdata));
endmodule

// ===== rtl/csmh_checker.sv =====
// port-level checks on the cuboid stacking block
module csmh_checker
  import csmh_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid, in_ready, in_last,
  input logic out_valid, out_ready,
  input hgt_t out_max_height
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_max_height))
    else $error("result dropped while stalled");
  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken with result pending");
  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready) else $error("solve not started");
  a_no_out_after_plain: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_last |=> !out_valid) else $error("spurious result");
endmodule

bind cuboid_stack_max_height csmh_checker u_chk (
  .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_last(in_ch.last),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_max_height(out_ch.max_height));
